// ===== rtl/core/tto_pkg.sv =====
`timescale 1ns / 1ps

package tto_pkg;

  localparam int VERT_BITS  = 63;
  localparam int SLOT_BITS  = 21;
  localparam int COORD_BITS = 21;

  localparam logic [3:0] ALL_VERTS = 4'hF;

  // Chunk width of the pipelined multiplier.
  localparam int MUL_CHUNK = 23;

  // Register stages from the input register to the result stage.
  localparam int PIPE_STAGES = 17;
  localparam int FIFO_DEPTH  = 32;

  // Edge vectors of a tet: e(k) = v(EDGE_HI[k]) - v(EDGE_LO[k]).
  localparam int EDGE_HI [5] = '{1, 2, 3, 2, 3};
  localparam int EDGE_LO [5] = '{0, 0, 0, 1, 1};

  // Faces: normal = cross(e(FACE_U), e(FACE_V)), oriented against e(FACE_SIDE)
  // (or toward it), based at vertex FACE_BASE.
  localparam int FACE_U      [4] = '{1, 0, 2, 3};
  localparam int FACE_V      [4] = '{0, 2, 1, 4};
  localparam int FACE_SIDE   [4] = '{2, 1, 0, 0};
  localparam int FACE_TOWARD [4] = '{0, 0, 0, 1};
  localparam int FACE_BASE   [4] = '{0, 0, 0, 1};

  // Cyclic component order for the cross product.
  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

  // Face pairs sharing an edge, in test order, and vertex pairs i < j.
  localparam int EDGE_F0 [6] = '{0, 0, 1, 0, 1, 2};
  localparam int EDGE_F1 [6] = '{1, 2, 2, 3, 3, 3};
  localparam int PAIR_I  [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J  [6] = '{1, 2, 3, 2, 3, 3};

endpackage

// ===== rtl/core/tto_ifs.sv =====
`timescale 1ns / 1ps

interface tto_req_if;
  logic                           valid;
  logic                           ready;
  logic [tto_pkg::VERT_BITS-1:0] a_vertex_0;
  logic [tto_pkg::VERT_BITS-1:0] a_vertex_1;
  logic [tto_pkg::VERT_BITS-1:0] a_vertex_2;
  logic [tto_pkg::VERT_BITS-1:0] a_vertex_3;
  logic [tto_pkg::VERT_BITS-1:0] b_vertex_0;
  logic [tto_pkg::VERT_BITS-1:0] b_vertex_1;
  logic [tto_pkg::VERT_BITS-1:0] b_vertex_2;
  logic [tto_pkg::VERT_BITS-1:0] b_vertex_3;

  modport source (output valid, a_vertex_0, a_vertex_1, a_vertex_2, a_vertex_3,
                  b_vertex_0, b_vertex_1, b_vertex_2, b_vertex_3, input ready);
  modport sink   (input valid, a_vertex_0, a_vertex_1, a_vertex_2, a_vertex_3,
                  b_vertex_0, b_vertex_1, b_vertex_2, b_vertex_3, output ready);
endinterface

interface tto_rsp_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink   (input valid, overlap, output ready);
endinterface

// ===== rtl/core/tto_mul.sv =====
`timescale 1ns / 1ps

// Signed multiplier, sign-magnitude, chunked partial products, five stages.
module tto_mul #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic                    clk,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int K  = tto_pkg::MUL_CHUNK;
  localparam int NA = (WA + K - 1) / K;
  localparam int NB = (WB + K - 1) / K;
  localparam int RW = (NB + 1) * K;
  localparam int TW = (NA + NB) * K;
  localparam int PW = WA + WB;

  logic [WA-1:0]   abs_a;
  logic [WB-1:0]   abs_b;
  logic [NA*K-1:0] ma;
  logic [NB*K-1:0] mb;
  logic [2*K-1:0]  pp [NA][NB];
  logic [RW-1:0]   row_next [NA];
  logic [RW-1:0]   row [NA];
  logic [TW-1:0]   tot_next;
  logic [PW-1:0]   tot;
  logic [3:0]      sg;

  assign abs_a = a[WA-1] ? WA'(~a + 1'b1) : WA'(a);
  assign abs_b = b[WB-1] ? WB'(~b + 1'b1) : WB'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (RW'(pp[i][j]) << (K * j));
      end
    end
    tot_next = '0;
    for (int i = 0; i < NA; i++) begin
      tot_next = tot_next + (TW'(row[i]) << (K * i));
    end
  end

  always_ff @(posedge clk) begin
    ma <= (NA*K)'(abs_a);
    mb <= (NB*K)'(abs_b);
    sg <= {sg[2:0], a[WA-1] ^ b[WB-1]};
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp[i][j] <= ma[i*K +: K] * mb[j*K +: K];
      end
    end
    row <= row_next;
    tot <= PW'(tot_next);
    p   <= sg[3] ? PW'(~tot + 1'b1) : tot;
  end

endmodule

// ===== rtl/core/tet_tet_overlap_test.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// req      in   valid / ready  a_vertex_0..3, b_vertex_0..3 (x:62..42 y:41..21 z:20..0)
// rsp      out  valid / ready  overlap (1 = no separating plane found)
//
// One request enters per cycle while a queue slot is free; its result is written
// to the output queue from the last pipeline stage and can leave at the next edge.
// The depth is set by the 69 x 69 bit edge determinants, built from 23-bit partial
// products in a five-stage multiplier after another such for the face plane
// distances. The datapath never stalls: a 32-entry result queue with a credit count
// holds ready low only while every queue slot is spoken for.
// Synchronous reset clears the valid bits, the count and the queue pointers.
module tet_tet_overlap_test #(
  parameter int COORD_BITS = tto_pkg::COORD_BITS
) (
  input logic       clk,
  input logic       rst,
  tto_req_if.sink   req,
  tto_rsp_if.source rsp
);

  localparam int CW  = COORD_BITS;
  localparam int EW  = CW + 1;          // edge and offset vectors
  localparam int PRW = 2 * CW + 2;      // cross product terms
  localparam int NW  = 2 * CW + 3;      // normal components
  localparam int MW  = NW + EW;         // normal x offset products
  localparam int DW  = 3 * CW + 6;      // plane distances
  localparam int EPW = 2 * DW;          // determinant products
  localparam int XW  = 2 * DW + 1;      // determinant
  localparam int NST = tto_pkg::PIPE_STAGES;
  localparam int FD  = tto_pkg::FIFO_DEPTH;
  localparam int AW  = $clog2(FD);

  typedef struct packed {
    logic [3:0]      flp;   // orientation flips of the faces of A
    logic [3:0][3:0] mska;  // B vertices outside each face of A
    logic [3:0][3:0] mskb;  // A vertices outside each face of B
  } side_t;

  logic acc, dlv;
  logic [tto_pkg::VERT_BITS-1:0] in_fld [8];

  logic [NST-1:0] vld;

  // Stage 0: coordinates. Index [tet][vertex][axis], tet 0 = A.
  logic signed [CW-1:0]  vtx [2][4][3];
  // Stages 1..3: edges and offsets of the other tet from each face base.
  logic signed [EW-1:0]  edg1 [2][5][3];
  logic signed [EW-1:0]  edg2 [2][5][3];
  logic signed [EW-1:0]  edg3 [2][5][3];
  logic signed [EW-1:0]  ofs1 [2][2][4][3];
  logic signed [EW-1:0]  ofs2 [2][2][4][3];
  logic signed [EW-1:0]  ofs3 [2][2][4][3];
  logic signed [PRW-1:0] cpr  [2][4][3][2];
  logic signed [NW-1:0]  nrm  [2][4][3];
  // Dot products: slot 0 is the orientation test, 1..4 the other tet's vertices.
  logic signed [MW-1:0]  prod [2][4][5][3];
  logic signed [DW-1:0]  dsum [2][4][5];

  logic                  flip_c [2][4];
  logic [3:0]            msk_c  [2][4];
  side_t                 side_next;
  side_t                 sidep [6];
  side_t                 side16;

  logic signed [EPW-1:0] emp   [6][6][2];
  logic signed [XW-1:0]  ediff [6][6];
  logic [5:0]            epos  [6];
  logic [5:0]            eneg  [6];
  logic                  ovl;

  logic [FD-1:0]         fbuf;
  logic [AW:0]           wp, rp, occ;

  function automatic int tpkg_slot(input int k);
    return tto_pkg::SLOT_BITS * (2 - k);
  endfunction

  assign acc = req.valid & req.ready;
  assign dlv = rsp.valid & rsp.ready;

  assign in_fld[0] = req.a_vertex_0;
  assign in_fld[1] = req.a_vertex_1;
  assign in_fld[2] = req.a_vertex_2;
  assign in_fld[3] = req.a_vertex_3;
  assign in_fld[4] = req.b_vertex_0;
  assign in_fld[5] = req.b_vertex_1;
  assign in_fld[6] = req.b_vertex_2;
  assign in_fld[7] = req.b_vertex_3;

  // Valid bits travel with the data; the datapath itself runs every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-2:0], acc};
    end
  end

  // Stages 0..3: unpack, edges and offsets, cross terms, normals.
  always_ff @(posedge clk) begin
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          // Keep the low COORD_BITS of each slot, x in the top slot.
          vtx[t][i][k] <= in_fld[t*4+i][tpkg_slot(k) +: CW];
        end
      end
    end
    for (int t = 0; t < 2; t++) begin
      for (int k = 0; k < 3; k++) begin
        for (int e = 0; e < 5; e++) begin
          edg1[t][e][k] <= EW'(vtx[t][tto_pkg::EDGE_HI[e]][k])
                         - EW'(vtx[t][tto_pkg::EDGE_LO[e]][k]);
        end
        for (int b = 0; b < 2; b++) begin
          for (int i = 0; i < 4; i++) begin
            ofs1[t][b][i][k] <= EW'(vtx[1-t][i][k]) - EW'(vtx[t][b][k]);
          end
        end
      end
    end
    edg2 <= edg1;
    edg3 <= edg2;
    ofs2 <= ofs1;
    ofs3 <= ofs2;
    for (int t = 0; t < 2; t++) begin
      for (int f = 0; f < 4; f++) begin
        for (int c = 0; c < 3; c++) begin
          cpr[t][f][c][0] <= PRW'(edg1[t][tto_pkg::FACE_U[f]][tto_pkg::NEXT1[c]])
                           * PRW'(edg1[t][tto_pkg::FACE_V[f]][tto_pkg::NEXT2[c]]);
          cpr[t][f][c][1] <= PRW'(edg1[t][tto_pkg::FACE_U[f]][tto_pkg::NEXT2[c]])
                           * PRW'(edg1[t][tto_pkg::FACE_V[f]][tto_pkg::NEXT1[c]]);
          nrm[t][f][c] <= NW'(cpr[t][f][c][0]) - NW'(cpr[t][f][c][1]);
        end
      end
    end
  end

  // Stages 4..8: normal against orientation edge and against each vertex offset.
  for (genvar t = 0; t < 2; t++) begin : g_tet
    for (genvar f = 0; f < 4; f++) begin : g_face
      for (genvar q = 0; q < 5; q++) begin : g_dot
        for (genvar c = 0; c < 3; c++) begin : g_axis
          logic signed [EW-1:0] opnd;
          if (q == 0) begin : g_side
            assign opnd = edg3[t][tto_pkg::FACE_SIDE[f]][c];
          end else begin : g_pt
            assign opnd = ofs3[t][tto_pkg::FACE_BASE[f]][q-1][c];
          end
          tto_mul #(.WA(NW), .WB(EW)) u_mul (
            .clk (clk),
            .a   (nrm[t][f][c]),
            .b   (opnd),
            .p   (prod[t][f][q][c])
          );
        end
      end
    end
  end

  // Stage 9: sum the three components; distances stay unoriented.
  always_ff @(posedge clk) begin
    for (int t = 0; t < 2; t++) begin
      for (int f = 0; f < 4; f++) begin
        for (int q = 0; q < 5; q++) begin
          dsum[t][f][q] <= DW'(prod[t][f][q][0]) + DW'(prod[t][f][q][1])
                         + DW'(prod[t][f][q][2]);
        end
      end
    end
  end

  // Orient each face and take the outside masks: strictly positive distance
  // after the flip.
  always_comb begin
    side_next = '0;
    for (int t = 0; t < 2; t++) begin
      for (int f = 0; f < 4; f++) begin
        flip_c[t][f] = (tto_pkg::FACE_TOWARD[f] != 0) ? dsum[t][f][0][DW-1]
                     : (~dsum[t][f][0][DW-1] & (|dsum[t][f][0]));
        for (int i = 0; i < 4; i++) begin
          msk_c[t][f][i] = flip_c[t][f] ? dsum[t][f][i+1][DW-1]
                         : (~dsum[t][f][i+1][DW-1] & (|dsum[t][f][i+1]));
        end
      end
    end
    for (int f = 0; f < 4; f++) begin
      side_next.flp[f]  = flip_c[0][f];
      side_next.mska[f] = msk_c[0][f];
      side_next.mskb[f] = msk_c[1][f];
    end
  end

  // Stages 10..15: hold masks and flips alongside the determinant pipe.
  always_ff @(posedge clk) begin
    sidep[0] <= side_next;
    for (int s = 1; s < 6; s++) begin
      sidep[s] <= sidep[s-1];
    end
  end

  // Stages 10..14: products of raw distances of A for each shared edge.
  for (genvar e = 0; e < 6; e++) begin : g_edge
    for (genvar p = 0; p < 6; p++) begin : g_pair
      tto_mul #(.WA(DW), .WB(DW)) u_mul_ji (
        .clk (clk),
        .a   (dsum[0][tto_pkg::EDGE_F0[e]][tto_pkg::PAIR_J[p]+1]),
        .b   (dsum[0][tto_pkg::EDGE_F1[e]][tto_pkg::PAIR_I[p]+1]),
        .p   (emp[e][p][0])
      );
      tto_mul #(.WA(DW), .WB(DW)) u_mul_ij (
        .clk (clk),
        .a   (dsum[0][tto_pkg::EDGE_F0[e]][tto_pkg::PAIR_I[p]+1]),
        .b   (dsum[0][tto_pkg::EDGE_F1[e]][tto_pkg::PAIR_J[p]+1]),
        .p   (emp[e][p][1])
      );
    end
  end

  // Stage 15: determinant; stage 16: its sign, corrected for face flips
  // (flipping either face negates the whole determinant).
  always_ff @(posedge clk) begin
    for (int e = 0; e < 6; e++) begin
      for (int p = 0; p < 6; p++) begin
        ediff[e][p] <= XW'(emp[e][p][0]) - XW'(emp[e][p][1]);
        if (sidep[5].flp[tto_pkg::EDGE_F0[e]] ^ sidep[5].flp[tto_pkg::EDGE_F1[e]]) begin
          epos[e][p] <= ediff[e][p][XW-1];
          eneg[e][p] <= ~ediff[e][p][XW-1] & (|ediff[e][p]);
        end else begin
          epos[e][p] <= ~ediff[e][p][XW-1] & (|ediff[e][p]);
          eneg[e][p] <= ediff[e][p][XW-1];
        end
      end
    end
    side16 <= sidep[5];
  end

  // Decision. Any separating plane clears the result; the faces of B count
  // only when every vertex of B is outside some face of A.
  always_comb begin
    logic [3:0] m0, m1, m0n, m1n, m_or;
    logic       fail, sep_a, sep_b;
    sep_a = 1'b0;
    sep_b = 1'b0;
    m_or  = '0;
    for (int f = 0; f < 4; f++) begin
      m_or = m_or | side16.mska[f];
      if (side16.mska[f] == tto_pkg::ALL_VERTS) sep_a = 1'b1;
      if (side16.mskb[f] == tto_pkg::ALL_VERTS) sep_b = 1'b1;
    end
    for (int e = 0; e < 6; e++) begin
      m0   = side16.mska[tto_pkg::EDGE_F0[e]];
      m1   = side16.mska[tto_pkg::EDGE_F1[e]];
      // Second mask uses the already updated first mask.
      m0n  = m0 & (m0 ^ m1);
      m1n  = m1 & (m0n ^ m1);
      fail = 1'b0;
      for (int p = 0; p < 6; p++) begin
        fail = fail
             | (m0n[tto_pkg::PAIR_I[p]] & m1n[tto_pkg::PAIR_J[p]] & epos[e][p])
             | (m0n[tto_pkg::PAIR_J[p]] & m1n[tto_pkg::PAIR_I[p]] & eneg[e][p]);
      end
      if (((m0 | m1) == tto_pkg::ALL_VERTS) && !fail) sep_a = 1'b1;
    end
    ovl = ~sep_a & ((m_or != tto_pkg::ALL_VERTS) | ~sep_b);
  end

  // Result queue with credits: every accepted request owns a slot.
  always_ff @(posedge clk) begin
    if (vld[NST-1]) begin
      fbuf[wp[AW-1:0]] <= ovl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      occ <= '0;
    end else begin
      if (vld[NST-1]) wp <= wp + 1'b1;
      if (dlv)        rp <= rp + 1'b1;
      occ <= occ + (AW+1)'(acc) - (AW+1)'(dlv);
    end
  end

  assign req.ready   = occ < (AW+1)'(FD);
  assign rsp.valid   = wp != rp;
  assign rsp.overlap = fbuf[rp[AW-1:0]];

endmodule
